[rtl/core/sample_ring_dac_port_top_macros.svh]
// ----------------------------------------------------------------------------
// Sample ring DAC port assertion macros
// Concurrent assertion wrappers shared by the RTL of the sample ring block.
// ----------------------------------------------------------------------------
`ifndef SAMPLE_RING_DAC_PORT_TOP_MACROS_SVH
`define SAMPLE_RING_DAC_PORT_TOP_MACROS_SVH

`ifndef SYNTH
// Checked on every rising clock edge, ignored while the reset is high.
`define SRDP_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("sample ring assertion failed");
// Checked on every rising clock edge, reset included.
`define SRDP_ASSERT_ALWAYS(name, clk, prop) \
   name: assert property (@(posedge clk) prop) \
      else $error("sample ring assertion failed");
`else
`define SRDP_ASSERT(name, clk, rst, prop)
`define SRDP_ASSERT_ALWAYS(name, clk, prop)
`endif

`endif

[rtl/core/srdp_pkg.sv]
// ----------------------------------------------------------------------------
// Sample ring DAC port package
// Action codes, register indexes, reset values and status frame constants.
// ----------------------------------------------------------------------------
`default_nettype none

package srdp_pkg;

   localparam int RING_DEPTH_DEFAULT = 4096;

   // Input actions.
   localparam logic [2:0] ACT_FEED  = 3'd0;
   localparam logic [2:0] ACT_CLOSE = 3'd1;
   localparam logic [2:0] ACT_READ  = 3'd2;
   localparam logic [2:0] ACT_WRITE = 3'd3;
   localparam logic [2:0] ACT_FRAME = 3'd4;

   // Configuration register indexes.
   localparam logic [2:0] CSR_SILENCE   = 3'd0;
   localparam logic [2:0] CSR_FRM_START = 3'd1;
   localparam logic [2:0] CSR_FRM_CMD   = 3'd2;
   localparam logic [2:0] CSR_STAT_PORT = 3'd3;
   localparam logic [2:0] CSR_DATA_PORT = 3'd4;
   localparam logic [2:0] CSR_CTRL_PORT = 3'd5;

   // Register reset values.
   localparam logic [7:0]  SILENCE_RESET   = 8'd128;
   localparam logic [7:0]  FRM_START_RESET = 8'd0;
   localparam logic [7:0]  FRM_CMD_RESET   = 8'd0;
   localparam logic [15:0] STAT_PORT_RESET = 16'd0;
   localparam logic [15:0] DATA_PORT_RESET = 16'd1;
   localparam logic [15:0] CTRL_PORT_RESET = 16'd2;

   // Status register bits.
   localparam int STAT_READY_BIT    = 0;
   localparam int STAT_ENDED_BIT    = 1;
   localparam int STAT_UNDERRUN_BIT = 2;

   // Status frame flag bits.
   localparam int FLAG_ARMED_BIT   = 0;
   localparam int FLAG_STARVED_BIT = 1;
   localparam int FLAG_ENDED_BIT   = 2;

   localparam int         FRAME_LEN     = 12;
   localparam logic [7:0] FRAME_PAYLOAD = 8'd7;
   localparam logic [7:0] READ_MISS     = 8'hFF;

endpackage

`default_nettype wire

[rtl/core/sample_ring_dac_port_top.sv]
// ----------------------------------------------------------------------------
// Sample ring DAC port
// Byte ring between a host feeder and a bus reader driving a DAC, with
// arm/stop control, underrun tracking and a 12-byte status frame.
// ----------------------------------------------------------------------------
// Usage:
// A transaction enters when start is high and busy is low; req_action picks
// feed, close, bus read, bus write or status frame, with req_bus_addr and
// req_data_byte as operands. Each result sits on the rsp_ ports for exactly
// one cycle with rsp_strobe high, and rsp_last marks the final result of a
// transaction. The receiver cannot stall, so the block never waits on it.
// Feed, close, bus write, a status read, a read of an unmapped address and a
// data read that does not pop give their result in the cycle after the
// accept, and busy stays low, so one such transaction is taken every cycle.
// A data read that pops the ring reads the sample memory through its
// registered read port: the read data register and then the result register
// lie between the accept and the result, and busy is high for one cycle.
// A status frame gives twelve results on consecutive cycles starting in the
// cycle after the accept; busy stays high while the remaining bytes are produced.
// Configuration is written through the csr_ channel, which is always ready.
// Reset clears the ring pointers, the played count and the flags and returns
// the held level and registers to their defaults. The sample memory is not
// cleared: only bytes that were fed are ever read back.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sample_ring_dac_port_top_macros.svh"

module sample_ring_dac_port_top #(
   parameter int RING_DEPTH = srdp_pkg::RING_DEPTH_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // Transaction request channel.
   input  wire logic        start,
   output logic             busy,
   input  wire logic [2:0]  req_action,
   input  wire logic [15:0] req_bus_addr,
   input  wire logic [7:0]  req_data_byte,
   // Result channel.
   output logic             rsp_strobe,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_accepted,
   output logic             rsp_last,
   // Configuration write channel.
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);

   import srdp_pkg::*;

   // Index width for the memory and counter width for the pointers, which
   // run modulo twice the depth so that full and empty can be told apart.
   localparam int IdxWidth = $clog2(RING_DEPTH);
   localparam int CntWidth = IdxWidth + 1;
   localparam logic [CntWidth-1:0] DepthCnt = CntWidth'(RING_DEPTH);
   localparam int FrameBits = FRAME_LEN * 8;
   localparam int FrmCntWidth = $clog2(FRAME_LEN);
   // The accept cycle already emits the first frame byte.
   localparam logic [FrmCntWidth-1:0] FrmCntLast = FrmCntWidth'(FRAME_LEN - 2);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_POP,
      ST_FRAME
   } state_type;

   // Sample memory with a registered read port.
   logic [7:0] sample_store [RING_DEPTH];
   logic [7:0] rd_data_ff;
   logic       mem_we;

   // Configuration registers.
   logic [7:0]  silence_ff,   silence_in;
   logic [7:0]  frm_start_ff, frm_start_in;
   logic [7:0]  frm_cmd_ff,   frm_cmd_in;
   logic [15:0] stat_port_ff, stat_port_in;
   logic [15:0] data_port_ff, data_port_in;
   logic [15:0] ctrl_port_ff, ctrl_port_in;

   // Ring and playback state.
   state_type           state_ff,       state_in;
   logic [CntWidth-1:0] write_count_ff, write_count_in;
   logic [CntWidth-1:0] read_count_ff,  read_count_in;
   logic [31:0]         played_ff,      played_in;
   logic [7:0]          held_ff,        held_in;
   logic                armed_ff,       armed_in;
   logic                closed_ff,      closed_in;
   logic                starved_ff,     starved_in;
   logic                stopped_ff,     stopped_in;

   // Frame sequencing.
   logic [FrameBits-1:0]   frame_ff,     frame_in;
   logic [FrmCntWidth-1:0] frame_cnt_ff, frame_cnt_in;

   // Registered result.
   logic       rsp_strobe_ff,   rsp_strobe_in;
   logic [7:0] rsp_out_byte_ff, rsp_out_byte_in;
   logic       rsp_accepted_ff, rsp_accepted_in;
   logic       rsp_last_ff,     rsp_last_in;

   // Derived status.
   logic [CntWidth-1:0]  level;
   logic [CntWidth-1:0]  room;
   logic [15:0]          room_word;
   logic                 ring_empty;
   logic                 ring_full;
   logic [7:0]           stat_byte;
   logic [7:0]           flag_byte;
   logic [7:0]           check_byte;
   logic [FrameBits-1:0] frame_word;
   logic                 accept;

   assign accept     = start && (state_ff == ST_IDLE);
   assign level      = write_count_ff - read_count_ff;
   assign room       = DepthCnt - level;
   assign room_word  = 16'(room);
   assign ring_empty = (level == '0);
   assign ring_full  = (level == DepthCnt);

   always_comb begin
      stat_byte = '0;
      stat_byte[STAT_READY_BIT]    = !ring_empty;
      stat_byte[STAT_ENDED_BIT]    = closed_ff && ring_empty;
      stat_byte[STAT_UNDERRUN_BIT] = starved_ff;
      flag_byte = '0;
      flag_byte[FLAG_ARMED_BIT]   = armed_ff;
      flag_byte[FLAG_STARVED_BIT] = starved_ff;
      flag_byte[FLAG_ENDED_BIT]   = (closed_ff && ring_empty) || stopped_ff;
   end

   // The check byte covers everything but the start byte.
   assign check_byte = frm_cmd_ff ^ FRAME_PAYLOAD ^ 8'h00 ^ room_word[7:0] ^
                       room_word[15:8] ^ played_ff[7:0] ^ played_ff[15:8] ^
                       played_ff[23:16] ^ played_ff[31:24] ^ flag_byte;

   // Frame bytes, first byte in the low bits.
   assign frame_word = {check_byte, flag_byte, played_ff[31:24], played_ff[23:16],
                        played_ff[15:8], played_ff[7:0], room_word[15:8],
                        room_word[7:0], 8'h00, FRAME_PAYLOAD, frm_cmd_ff,
                        frm_start_ff};

   always_comb begin
      silence_in      = silence_ff;
      frm_start_in    = frm_start_ff;
      frm_cmd_in      = frm_cmd_ff;
      stat_port_in    = stat_port_ff;
      data_port_in    = data_port_ff;
      ctrl_port_in    = ctrl_port_ff;
      state_in        = state_ff;
      write_count_in  = write_count_ff;
      read_count_in   = read_count_ff;
      played_in       = played_ff;
      held_in         = held_ff;
      armed_in        = armed_ff;
      closed_in       = closed_ff;
      starved_in      = starved_ff;
      stopped_in      = stopped_ff;
      frame_in        = frame_ff;
      frame_cnt_in    = frame_cnt_ff;
      rsp_strobe_in   = 1'b0;
      rsp_out_byte_in = '0;
      rsp_accepted_in = 1'b0;
      rsp_last_in     = 1'b0;
      mem_we          = 1'b0;

      // Register writes must arrive only while the block is idle; the block does not enforce it.
      if (csr_valid) begin
         unique case (csr_index)
            CSR_SILENCE:   silence_in   = csr_wdata[7:0];
            CSR_FRM_START: frm_start_in = csr_wdata[7:0];
            CSR_FRM_CMD:   frm_cmd_in   = csr_wdata[7:0];
            CSR_STAT_PORT: stat_port_in = csr_wdata;
            CSR_DATA_PORT: data_port_in = csr_wdata;
            CSR_CTRL_PORT: ctrl_port_in = csr_wdata;
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_strobe_in = 1'b1;
               rsp_last_in   = 1'b1;
               unique case (req_action)
                  ACT_FEED: begin
                     // A byte fed into a full ring is dropped.
                     if (!ring_full) begin
                        mem_we          = 1'b1;
                        write_count_in  = write_count_ff + CntWidth'(1);
                        rsp_accepted_in = 1'b1;
                     end
                  end
                  ACT_CLOSE: begin
                     closed_in = 1'b1;
                  end
                  ACT_READ: begin
                     // The status port wins when it shares the data address.
                     if (req_bus_addr == stat_port_ff) begin
                        rsp_out_byte_in = stat_byte;
                     end else if (req_bus_addr != data_port_ff) begin
                        rsp_out_byte_in = READ_MISS;
                     end else if (!armed_ff) begin
                        rsp_out_byte_in = held_ff;
                     end else if (ring_empty) begin
                        // Underrun: repeat the held level.
                        if (!closed_ff) begin
                           starved_in = 1'b1;
                        end
                        rsp_out_byte_in = held_ff;
                     end else begin
                        // The memory read issued at this edge returns next
                        // cycle, where the result is produced.
                        read_count_in = read_count_ff + CntWidth'(1);
                        played_in     = played_ff + 32'd1;
                        rsp_strobe_in = 1'b0;
                        rsp_last_in   = 1'b0;
                        state_in      = ST_POP;
                     end
                  end
                  ACT_WRITE: begin
                     if (req_bus_addr == ctrl_port_ff) begin
                        rsp_accepted_in = 1'b1;
                        if (req_data_byte != 8'h00) begin
                           armed_in   = 1'b1;
                           starved_in = 1'b0;
                           stopped_in = 1'b0;
                        end else begin
                           // Stop flushes the ring and returns to silence.
                           armed_in      = 1'b0;
                           read_count_in = write_count_ff;
                           closed_in     = 1'b0;
                           stopped_in    = 1'b1;
                           held_in       = silence_ff;
                        end
                     end
                  end
                  ACT_FRAME: begin
                     rsp_out_byte_in = frame_word[7:0];
                     rsp_last_in     = 1'b0;
                     frame_in        = frame_word >> 8;
                     frame_cnt_in    = '0;
                     state_in        = ST_FRAME;
                  end
                  default: begin
                     rsp_strobe_in = 1'b0;
                     rsp_last_in   = 1'b0;
                  end
               endcase
            end
         end
         ST_POP: begin
            rsp_strobe_in   = 1'b1;
            rsp_last_in     = 1'b1;
            rsp_out_byte_in = rd_data_ff;
            held_in         = rd_data_ff;
            state_in        = ST_IDLE;
         end
         ST_FRAME: begin
            rsp_strobe_in   = 1'b1;
            rsp_out_byte_in = frame_ff[7:0];
            frame_in        = frame_ff >> 8;
            frame_cnt_in    = frame_cnt_ff + FrmCntWidth'(1);
            if (frame_cnt_ff == FrmCntLast) begin
               rsp_last_in = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Sample memory: one write port, one registered read port. The read
   // address is the pop pointer, sampled at the edge that accepts a read.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         sample_store[write_count_ff[IdxWidth-1:0]] <= req_data_byte;
      end
      rd_data_ff <= sample_store[read_count_ff[IdxWidth-1:0]];
   end

   // State, configuration and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         silence_ff     <= SILENCE_RESET;
         frm_start_ff   <= FRM_START_RESET;
         frm_cmd_ff     <= FRM_CMD_RESET;
         stat_port_ff   <= STAT_PORT_RESET;
         data_port_ff   <= DATA_PORT_RESET;
         ctrl_port_ff   <= CTRL_PORT_RESET;
         state_ff       <= ST_IDLE;
         write_count_ff <= '0;
         read_count_ff  <= '0;
         played_ff      <= '0;
         held_ff        <= SILENCE_RESET;
         armed_ff       <= 1'b0;
         closed_ff      <= 1'b0;
         starved_ff     <= 1'b0;
         stopped_ff     <= 1'b0;
         frame_cnt_ff   <= '0;
         rsp_strobe_ff  <= 1'b0;
         rsp_last_ff    <= 1'b0;
      end else begin
         silence_ff     <= silence_in;
         frm_start_ff   <= frm_start_in;
         frm_cmd_ff     <= frm_cmd_in;
         stat_port_ff   <= stat_port_in;
         data_port_ff   <= data_port_in;
         ctrl_port_ff   <= ctrl_port_in;
         state_ff       <= state_in;
         write_count_ff <= write_count_in;
         read_count_ff  <= read_count_in;
         played_ff      <= played_in;
         held_ff        <= held_in;
         armed_ff       <= armed_in;
         closed_ff      <= closed_in;
         starved_ff     <= starved_in;
         stopped_ff     <= stopped_in;
         frame_cnt_ff   <= frame_cnt_in;
         rsp_strobe_ff  <= rsp_strobe_in;
         rsp_last_ff    <= rsp_last_in;
      end
      frame_ff        <= frame_in;
      rsp_out_byte_ff <= rsp_out_byte_in;
      rsp_accepted_ff <= rsp_accepted_in;
   end

   assign busy         = (state_ff != ST_IDLE);
   assign csr_ready    = 1'b1;
   assign rsp_strobe   = rsp_strobe_ff;
   assign rsp_out_byte = rsp_out_byte_ff;
   assign rsp_accepted = rsp_accepted_ff;
   assign rsp_last     = rsp_last_ff;

   // The fill level never exceeds the ring depth once the pointers are reset.
   `SRDP_ASSERT(a_level_bound, clock, reset, level <= DepthCnt)
   // A pop cycle always delivers its sample in the next cycle.
   `SRDP_ASSERT(a_pop_result, clock, reset, state_ff == ST_POP |=> rsp_strobe && rsp_last)
   // An accepted frame starts with a non-final byte and keeps the block busy.
   `SRDP_ASSERT(a_frame_start, clock, reset,
      accept && req_action == ACT_FRAME |=> busy && rsp_strobe && !rsp_last)
   // The final frame byte releases the block.
   `SRDP_ASSERT(a_frame_end, clock, reset,
      state_ff == ST_FRAME && frame_cnt_ff == FrmCntLast |=> !busy && rsp_last)

endmodule

`default_nettype wire

[sim/sample_ring_dac_port_top_tb.sv]
// ----------------------------------------------------------------------------
// Sample ring DAC port testbench
// Drives feed, close, bus read, bus write and status frame transactions into
// the sample ring through its start/busy channel. A scoreboard keeps its own
// copy of the ring, counters, flags and registers, and checks every strobed
// result field by field. The run covers a directed opening, a feed and drain
// pass, and random traffic under several register settings.
// ----------------------------------------------------------------------------

import srdp_pkg::*;

typedef struct packed {
   logic [7:0] out_byte;
   logic       accepted;
   logic       last;
} dac_rsp_t;

// Scoreboard: predicts the results of each accepted transaction and checks the
// results that the block strobes out, oldest expectation first.
class sample_ring_scoreboard;
   logic [7:0]  silence_level;
   logic [7:0]  frame_start;
   logic [7:0]  frame_cmd;
   logic [15:0] stat_port;
   logic [15:0] data_port;
   logic [15:0] ctrl_port;

   logic [7:0]  ring [RING_DEPTH_DEFAULT];
   int unsigned wr_cnt;
   int unsigned rd_cnt;
   logic [31:0] played;
   logic [7:0]  held;
   bit          armed;
   bit          closed;
   bit          starved;
   bit          stopped;

   dac_rsp_t    rsp_due[$];
   int unsigned errors;

   function new();
      errors = 0;
      silence_level = SILENCE_RESET;
      frame_start = FRM_START_RESET;
      frame_cmd = FRM_CMD_RESET;
      stat_port = STAT_PORT_RESET;
      data_port = DATA_PORT_RESET;
      ctrl_port = CTRL_PORT_RESET;
      wr_cnt = 0;
      rd_cnt = 0;
      played = '0;
      held = SILENCE_RESET;
      armed = 0;
      closed = 0;
      starved = 0;
      stopped = 0;
   endfunction

   function void set_reg(logic [2:0] idx, logic [15:0] val);
      case (idx)
         CSR_SILENCE:   silence_level = val[7:0];
         CSR_FRM_START: frame_start = val[7:0];
         CSR_FRM_CMD:   frame_cmd = val[7:0];
         CSR_STAT_PORT: stat_port = val;
         CSR_DATA_PORT: data_port = val;
         CSR_CTRL_PORT: ctrl_port = val;
         default: ;
      endcase
   endfunction

   function int unsigned ring_level();
      return (wr_cnt + 2 * RING_DEPTH_DEFAULT - rd_cnt) % (2 * RING_DEPTH_DEFAULT);
   endfunction

   function logic [7:0] read_bus(logic [15:0] addr);
      int unsigned lvl;
      logic [7:0] st;
      lvl = ring_level();
      st = '0;
      if (addr == stat_port) begin
         st[STAT_READY_BIT] = (lvl != 0);
         st[STAT_ENDED_BIT] = closed && (lvl == 0);
         st[STAT_UNDERRUN_BIT] = starved;
         return st;
      end
      if (addr != data_port)
         return READ_MISS;
      if (!armed)
         return held;
      if (lvl == 0) begin
         if (!closed)
            starved = 1;
         return held;
      end
      held = ring[rd_cnt % RING_DEPTH_DEFAULT];
      rd_cnt = (rd_cnt + 1) % (2 * RING_DEPTH_DEFAULT);
      played = played + 32'd1;
      return held;
   endfunction

   function logic write_bus(logic [15:0] addr, logic [7:0] val);
      if (addr != ctrl_port)
         return 1'b0;
      if (val != 8'h00) begin
         armed = 1;
         starved = 0;
         stopped = 0;
      end else begin
         armed = 0;
         rd_cnt = wr_cnt;
         closed = 0;
         stopped = 1;
         held = silence_level;
      end
      return 1'b1;
   endfunction

   // Works out the results of one accepted transaction and queues them.
   function void note_request(logic [2:0] act, logic [15:0] addr, logic [7:0] dat);
      dac_rsp_t r;
      logic [7:0] frm [FRAME_LEN];
      logic [15:0] room;
      logic [7:0] flags;
      logic [7:0] chk;
      r = '{out_byte: 8'h00, accepted: 1'b0, last: 1'b1};
      case (act)
         ACT_FEED: begin
            if (ring_level() < RING_DEPTH_DEFAULT) begin
               ring[wr_cnt % RING_DEPTH_DEFAULT] = dat;
               wr_cnt = (wr_cnt + 1) % (2 * RING_DEPTH_DEFAULT);
               r.accepted = 1'b1;
            end
            rsp_due.push_back(r);
         end
         ACT_CLOSE: begin
            closed = 1;
            rsp_due.push_back(r);
         end
         ACT_READ: begin
            r.out_byte = read_bus(addr);
            rsp_due.push_back(r);
         end
         ACT_WRITE: begin
            r.accepted = write_bus(addr, dat);
            rsp_due.push_back(r);
         end
         ACT_FRAME: begin
            room = 16'(RING_DEPTH_DEFAULT - ring_level());
            flags = '0;
            flags[FLAG_ARMED_BIT] = armed;
            flags[FLAG_STARVED_BIT] = starved;
            flags[FLAG_ENDED_BIT] = (closed && ring_level() == 0) || stopped;
            frm[0] = frame_start;
            frm[1] = frame_cmd;
            frm[2] = FRAME_PAYLOAD;
            frm[3] = 8'h00;
            frm[4] = room[7:0];
            frm[5] = room[15:8];
            frm[6] = played[7:0];
            frm[7] = played[15:8];
            frm[8] = played[23:16];
            frm[9] = played[31:24];
            frm[10] = flags;
            chk = '0;
            for (int i = 1; i < FRAME_LEN - 1; i++)
               chk ^= frm[i];
            frm[11] = chk;
            for (int i = 0; i < FRAME_LEN; i++) begin
               r.out_byte = frm[i];
               r.last = (i == FRAME_LEN - 1);
               rsp_due.push_back(r);
            end
         end
         default: ;
      endcase
   endfunction

   function void check_rsp(logic [7:0] got_byte, logic got_acc, logic got_last);
      dac_rsp_t exp;
      if (rsp_due.size() == 0) begin
         $display("%0t: unexpected result, expected none, got byte %02h acc %b last %b",
                  $time, got_byte, got_acc, got_last);
         errors++;
         return;
      end
      exp = rsp_due.pop_front();
      if (got_byte !== exp.out_byte) begin
         $display("%0t: out_byte expected %02h, got %02h", $time, exp.out_byte, got_byte);
         errors++;
      end
      if (got_acc !== exp.accepted) begin
         $display("%0t: accepted expected %b, got %b", $time, exp.accepted, got_acc);
         errors++;
      end
      if (got_last !== exp.last) begin
         $display("%0t: last expected %b, got %b", $time, exp.last, got_last);
         errors++;
      end
   endfunction

   function int unsigned pending();
      return rsp_due.size();
   endfunction
endclass

module sample_ring_dac_port_top_tb;

   // The ring runs at its default depth, so room matches the block as it is
   // normally built.
   localparam int RING_DEPTH = RING_DEPTH_DEFAULT;

   // Far above the slowest correct run: every transaction a full frame plus
   // the longest sender gap, several times over.
   localparam int CYCLE_LIMIT = 500000;

   // Codes that name no action; the block must swallow them without results.
   localparam logic [2:0] ACT_RSVD_A = 3'd5;
   localparam logic [2:0] ACT_RSVD_B = 3'd6;
   localparam logic [2:0] ACT_RSVD_C = 3'd7;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [2:0]  req_action;
   logic [15:0] req_bus_addr;
   logic [7:0]  req_data_byte;
   logic        rsp_strobe;
   logic [7:0]  rsp_out_byte;
   logic        rsp_accepted;
   logic        rsp_last;
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_index;
   logic [15:0] csr_wdata;

   sample_ring_scoreboard sb;

   // Transactions left in the current sender burst; at zero a new burst is
   // drawn, usually preceded by a gap with start low.
   int burst_left;

   sample_ring_dac_port_top #(
      .RING_DEPTH(RING_DEPTH)
   ) uut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_action(req_action),
      .req_bus_addr(req_bus_addr),
      .req_data_byte(req_data_byte),
      .rsp_strobe(rsp_strobe),
      .rsp_out_byte(rsp_out_byte),
      .rsp_accepted(rsp_accepted),
      .rsp_last(rsp_last),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Result monitor. The block's outputs change only after the edge, so the
   // values read here are those of the cycle that the edge closes. A result is
   // valid for that single cycle and cannot be held off.
   always @(posedge clock) begin
      if (!reset && rsp_strobe !== 1'b0)
         sb.check_rsp(rsp_out_byte, rsp_accepted, rsp_last);
   end

   // Watchdog: a run that does not finish in time counts as a failure.
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("Mismatches found");
      $finish;
   end

   // Presents one transaction and holds it until the block takes it. Called
   // right after a rising edge. Start stays high across a burst, so it is
   // only written low at the head of a gap.
   task automatic send_item(input logic [2:0] act, input logic [15:0] addr,
                            input logic [7:0] dat);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      start <= 1'b1;
      req_action <= act;
      req_bus_addr <= addr;
      req_data_byte <= dat;
      // The transaction moves at the first edge that finds busy low.
      do @(posedge clock); while (busy !== 1'b0);
      sb.note_request(act, addr, dat);
   endtask

   // Stops the sender and waits until every expected result has come, then keeps
   // waiting in case a swallowed transaction is still in flight.
   task automatic wait_drained();
      start <= 1'b0;
      burst_left = 0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // One register write. Valid stays high between back-to-back writes; the
   // caller lowers it after the last one.
   task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (csr_ready !== 1'b1);
      sb.set_reg(idx, val);
   endtask

   // Writes the full register set while the block is idle.
   task automatic load_regs(input logic [7:0] sil, input logic [7:0] fstart,
                            input logic [7:0] fcmd, input logic [15:0] sport,
                            input logic [15:0] dport, input logic [15:0] cport);
      write_reg(CSR_SILENCE, {8'h00, sil});
      write_reg(CSR_FRM_START, {8'h00, fstart});
      write_reg(CSR_FRM_CMD, {8'h00, fcmd});
      write_reg(CSR_STAT_PORT, sport);
      write_reg(CSR_DATA_PORT, dport);
      write_reg(CSR_CTRL_PORT, cport);
      csr_valid <= 1'b0;
   endtask

   // Random traffic weighted toward the transactions that move samples:
   // feeds and data reads dominate, so the ring fills, drains and starves.
   // Arm, stop, close and frames keep the flags moving; stray addresses and
   // undefined actions are the noise.
   task automatic send_random(input int count);
      int pick;
      logic [15:0] addr;
      logic [7:0] dat;
      repeat (count) begin
         pick = $urandom_range(0, 99);
         addr = 16'($urandom_range(0, 65535));
         dat = 8'($urandom_range(0, 255));
         if (pick < 30)
            send_item(ACT_FEED, addr, dat);
         else if (pick < 58)
            send_item(ACT_READ, sb.data_port, dat);
         else if (pick < 66)
            send_item(ACT_READ, sb.stat_port, dat);
         else if (pick < 70)
            send_item(ACT_READ, addr, dat);
         else if (pick < 77)
            send_item(ACT_WRITE, sb.ctrl_port, (dat == 8'h00) ? 8'h01 : dat);
         else if (pick < 81)
            send_item(ACT_WRITE, sb.ctrl_port, 8'h00);
         else if (pick < 85)
            send_item(ACT_WRITE, addr, dat);
         else if (pick < 89)
            send_item(ACT_CLOSE, addr, dat);
         else if (pick < 96)
            send_item(ACT_FRAME, addr, dat);
         else
            send_item(ACT_FRAME + 3'($urandom_range(1, 3)), addr, dat);
      end
   endtask

   initial begin
      sb = new();
      burst_left = 0;
      reset <= 1'b1;
      start <= 1'b0;
      req_action <= ACT_FEED;
      req_bus_addr <= '0;
      req_data_byte <= '0;
      csr_valid <= 1'b0;
      csr_index <= CSR_SILENCE;
      csr_wdata <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed opening with the reset register values: status port 0,
      // data port 1, ctrl port 2, silence 128.
      send_item(ACT_FRAME, 16'h0000, 8'h00);          // empty ring, no flags
      send_item(ACT_READ, STAT_PORT_RESET, 8'h00);    // nothing ready
      send_item(ACT_READ, DATA_PORT_RESET, 8'h00);    // not armed: silence
      send_item(ACT_READ, 16'hFFFF, 8'hFF);           // unmapped address
      send_item(ACT_READ, CTRL_PORT_RESET, 8'h00);    // ctrl cannot be read
      send_item(ACT_WRITE, 16'h1234, 8'h55);          // write that misses ctrl
      send_item(ACT_FEED, 16'h0000, 8'h00);
      send_item(ACT_FEED, 16'hFFFF, 8'hFF);
      send_item(ACT_FEED, 16'h5A5A, 8'hA5);
      send_item(ACT_READ, DATA_PORT_RESET, 8'h00);    // still not armed
      send_item(ACT_WRITE, CTRL_PORT_RESET, 8'hFF);   // arm
      send_item(ACT_READ, DATA_PORT_RESET, 8'h00);
      send_item(ACT_READ, DATA_PORT_RESET, 8'h00);
      send_item(ACT_READ, DATA_PORT_RESET, 8'h00);
      send_item(ACT_READ, DATA_PORT_RESET, 8'h00);    // empty while armed
      send_item(ACT_READ, STAT_PORT_RESET, 8'h00);    // underrun shows
      send_item(ACT_FRAME, 16'h0000, 8'h00);
      send_item(ACT_WRITE, CTRL_PORT_RESET, 8'h01);   // re-arm clears underrun
      send_item(ACT_CLOSE, 16'h0000, 8'h00);
      send_item(ACT_READ, DATA_PORT_RESET, 8'h00);    // empty but closed
      send_item(ACT_READ, STAT_PORT_RESET, 8'h00);    // stream ended
      send_item(ACT_WRITE, CTRL_PORT_RESET, 8'h00);   // stop and flush
      send_item(ACT_FRAME, 16'h0000, 8'h00);          // ended through stop
      send_item(ACT_RSVD_A, 16'hFFFF, 8'hFF);
      send_item(ACT_RSVD_B, 16'h0000, 8'h00);
      send_item(ACT_RSVD_C, 16'h8001, 8'h81);

      // Feed a batch while stopped, then arm, pop some and feed again so both
      // pointers move on.
      repeat (24)
         send_item(ACT_FEED, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
      send_item(ACT_FRAME, 16'h0000, 8'h00);          // room after the batch
      send_item(ACT_WRITE, CTRL_PORT_RESET, 8'h80);
      repeat (16) send_item(ACT_READ, DATA_PORT_RESET, 8'h00);
      repeat (20)
         send_item(ACT_FEED, 16'h0000, 8'($urandom_range(0, 255)));
      send_item(ACT_FRAME, 16'h0000, 8'h00);
      send_random(22);

      // Extreme register values, with the silence level changed so that it only
      // shows after the next stop.
      wait_drained();
      load_regs(8'h00, 8'hFF, 8'h00, 16'hFFFF, 16'h0000, 16'h8000);
      send_random(22);

      // The opposite extremes, and the status and data ports on one address:
      // reads of that address must report status.
      wait_drained();
      load_regs(8'hFF, 8'h00, 8'hFF, 16'h1234, 16'h1234, 16'hFFFF);
      send_item(ACT_READ, 16'h1234, 8'h00);
      send_random(22);

      // Random register values.
      wait_drained();
      load_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
      send_random(22);

      wait_drained();
      if (sb.errors == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
